// ===== design/ciu_pkg.sv =====
// Shared widths, constants, register indexes and controller/datapath types
// for the calcium/IP3 cell update unit. No dependencies.
`default_nettype none

package ciu_pkg;

  localparam int RATE_W     = 24;
  localparam int CONC_W     = 20;
  localparam int IP3_W      = 19;
  localparam int TIME_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = 16;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 50;
  localparam int INC_W      = PROD_W - FRAC_W;
  localparam int SUM_W      = INC_W + 1;
  localparam int DIV_CNT_W  = $clog2(QUO_W);

  localparam logic [IP3_W-1:0]  IP3_MAX    = 19'd327680;
  localparam logic [IP3_W-1:0]  Q_ONE      = 19'd65536;
  localparam logic [CONC_W-1:0] CA_MAX     = 20'd655360;
  localparam logic [CONC_W-1:0] BASE_RESET = 20'd6554;
  localparam logic [CONC_W-1:0] THR_RESET  = 20'd32768;
  localparam logic [RATE_W-1:0] PROD_RESET = 24'd65536;
  localparam logic [RATE_W-1:0] DEG_RESET  = 24'd32768;
  localparam logic [RATE_W-1:0] FLUX_RESET = 24'd65536;
  localparam logic [RATE_W-1:0] UPT_RESET  = 24'd32768;
  localparam logic [TIME_W-1:0] REFRACTORY_US = 48'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROD = 3'd0,
    CFG_DEG  = 3'd1,
    CFG_FLUX = 3'd2,
    CFG_UPT  = 3'd3,
    CFG_BASE = 3'd4,
    CFG_THR  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_PROD_STIM = 3'd0,
    MS_DEG_IP3   = 3'd1,
    MS_IP3_DT    = 3'd2,
    MS_FLUX_FAC  = 3'd3,
    MS_UPT_DIFF  = 3'd4,
    MS_CA_DT     = 3'd5
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     skip_out;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_sub;
    logic     ip3_upd;
    logic     div_init;
    logic     div_step;
    logic     ca_upd;
  } ciu_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_last;
  } ciu_sts_t;

endpackage

`default_nettype wire

// ===== design/ciu_in_if.sv =====
// Input item channel: valid/ready handshake with step, stimulus and timestamp.
// Depends on ciu_pkg.
`default_nettype none

interface ciu_in_if;
  import ciu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [RATE_W-1:0]        time_step;
  logic signed [RATE_W-1:0] stimulus;
  logic [TIME_W-1:0]        now_us;

  modport source (output valid, output time_step, output stimulus, output now_us,
                  input ready);
  modport sink   (input valid, input time_step, input stimulus, input now_us,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ciu_out_if.sv =====
// Result item channel: valid/ready handshake with IP3, calcium and flags.
// Depends on ciu_pkg.
`default_nettype none

interface ciu_out_if;
  import ciu_pkg::*;

  logic              valid;
  logic              ready;
  logic [IP3_W-1:0]  ip3_level;
  logic [CONC_W-1:0] calcium_level;
  logic              spike;
  logic              skipped;

  modport source (output valid, output ip3_level, output calcium_level, output spike,
                  output skipped, input ready);
  modport sink   (input valid, input ip3_level, input calcium_level, input spike,
                  input skipped, output ready);
endinterface

`default_nettype wire

// ===== design/ciu_ctrl.sv =====
// Sequencer for one Euler step: walks the shared multiplier, the divider and
// the state updates. Depends on ciu_pkg.
`default_nettype none

module ciu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ciu_pkg::ciu_sts_t sts,
  output ciu_pkg::ciu_cmd_t      cmd
);
  import ciu_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_M1   = 14'b00000000000010,
    ST_M2   = 14'b00000000000100,
    ST_SUB1 = 14'b00000000001000,
    ST_M3   = 14'b00000000010000,
    ST_IP3  = 14'b00000000100000,
    ST_DIVI = 14'b00000001000000,
    ST_DIV  = 14'b00000010000000,
    ST_M4   = 14'b00000100000000,
    ST_M5   = 14'b00001000000000,
    ST_SUB2 = 14'b00010000000000,
    ST_M6   = 14'b00100000000000,
    ST_CA   = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MS_PROD_STIM;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (sts.dt_zero) begin
            cmd.skip_out = 1'b1;
            state_nxt    = ST_OUT;
          end else begin
            state_nxt = ST_M1;
          end
        end
      end
      ST_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_PROD_STIM;
        state_nxt   = ST_M2;
      end
      ST_M2: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_DEG_IP3;
        state_nxt    = ST_SUB1;
      end
      ST_SUB1: begin
        cmd.acc_sub = 1'b1;
        state_nxt   = ST_M3;
      end
      ST_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_IP3_DT;
        state_nxt   = ST_IP3;
      end
      ST_IP3: begin
        cmd.ip3_upd = 1'b1;
        state_nxt   = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_M4;
        end
      end
      ST_M4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_FLUX_FAC;
        state_nxt   = ST_M5;
      end
      ST_M5: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_UPT_DIFF;
        state_nxt    = ST_SUB2;
      end
      ST_SUB2: begin
        cmd.acc_sub = 1'b1;
        state_nxt   = ST_M6;
      end
      ST_M6: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_CA_DT;
        state_nxt   = ST_CA;
      end
      ST_CA: begin
        cmd.ca_upd = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_skip_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.dt_zero) |=> out_valid)
    else $error("zero-step item did not produce a result next cycle");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !sts.dt_zero) |=> (!out_valid && !in_ready))
    else $error("stepping item left the busy sequence early");

endmodule

`default_nettype wire

// ===== design/ciu_dpath.sv =====
// Datapath: configuration registers, cell state, shared multiplier with
// accumulator, restoring divider and result register. Depends on ciu_pkg.
`default_nettype none

module ciu_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ciu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ciu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [ciu_pkg::RATE_W-1:0]        in_time_step,
  input  wire logic signed [ciu_pkg::RATE_W-1:0] in_stimulus,
  input  wire logic [ciu_pkg::TIME_W-1:0]        in_now_us,
  input  wire ciu_pkg::ciu_cmd_t                 cmd,
  output ciu_pkg::ciu_sts_t                      sts,
  output logic [ciu_pkg::IP3_W-1:0]              out_ip3_level,
  output logic [ciu_pkg::CONC_W-1:0]             out_calcium_level,
  output logic                                   out_spike,
  output logic                                   out_skipped
);
  import ciu_pkg::*;

  logic [RATE_W-1:0]        prod_r, deg_r, flux_r, upt_r;
  logic [CONC_W-1:0]        base_r, thr_r;
  logic [IP3_W-1:0]         ip3_r;
  logic [CONC_W-1:0]        ca_r;
  logic [TIME_W-1:0]        last_r;
  logic [RATE_W-1:0]        dt_r;
  logic signed [RATE_W-1:0] stim_r;
  logic [TIME_W-1:0]        now_r;
  logic signed [PROD_W-1:0] p_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [IP3_W-1:0]         rem_r, dvs_r;
  logic [QUO_W-1:0]         quo_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic [IP3_W-1:0]         oip3_r;
  logic [CONC_W-1:0]        oca_r;
  logic                     ospk_r, oskp_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [CONC_W:0]    ca_diff;
  logic signed [INC_W-1:0]   inc;
  logic signed [SUM_W-1:0]   ip3_sum, ca_sum, ca_cap;
  logic [IP3_W-1:0]          ip3_new;
  logic [CONC_W-1:0]         ca_new;
  logic [IP3_W:0]            rem2;
  logic                      div_ge;
  logic [TIME_W-1:0]         since;
  logic                      spike_hit;

  assign ca_diff = $signed({1'b0, ca_r}) - $signed({1'b0, base_r});

  always_comb begin
    case (cmd.mul_sel)
      MS_PROD_STIM: begin
        mul_a = {{(MUL_A_W-RATE_W){stim_r[RATE_W-1]}}, stim_r};
        mul_b = {1'b0, prod_r};
      end
      MS_DEG_IP3: begin
        mul_a = {{(MUL_A_W-IP3_W){1'b0}}, ip3_r};
        mul_b = {1'b0, deg_r};
      end
      MS_IP3_DT, MS_CA_DT: begin
        mul_a = acc_r[ACC_W-1:FRAC_W];
        mul_b = {1'b0, dt_r};
      end
      MS_FLUX_FAC: begin
        mul_a = {{(MUL_A_W-QUO_W){1'b0}}, quo_r};
        mul_b = {1'b0, flux_r};
      end
      MS_UPT_DIFF: begin
        mul_a = {{(MUL_A_W-CONC_W-1){ca_diff[CONC_W]}}, ca_diff};
        mul_b = {1'b0, upt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign inc   = p_r[PROD_W-1:FRAC_W];

  always_comb begin
    ip3_sum = $signed({{(SUM_W-IP3_W){1'b0}}, ip3_r}) + $signed({inc[INC_W-1], inc});
    if (ip3_sum[SUM_W-1]) begin
      ip3_new = '0;
    end else if (ip3_sum > $signed({{(SUM_W-IP3_W){1'b0}}, IP3_MAX})) begin
      ip3_new = IP3_MAX;
    end else begin
      ip3_new = ip3_sum[IP3_W-1:0];
    end
  end

  always_comb begin
    ca_sum = $signed({{(SUM_W-CONC_W){1'b0}}, ca_r}) + $signed({inc[INC_W-1], inc});
    if (ca_sum > $signed({{(SUM_W-CONC_W){1'b0}}, CA_MAX})) begin
      ca_cap = $signed({{(SUM_W-CONC_W){1'b0}}, CA_MAX});
    end else begin
      ca_cap = ca_sum;
    end
    if (ca_cap < $signed({{(SUM_W-CONC_W){1'b0}}, base_r})) begin
      ca_new = base_r;
    end else begin
      ca_new = ca_cap[CONC_W-1:0];
    end
  end

  assign rem2   = {rem_r, 1'b0};
  assign div_ge = rem2 >= {1'b0, dvs_r};

  assign since     = now_r - last_r;
  assign spike_hit = (ca_new >= thr_r) && (since > REFRACTORY_US);

  assign sts.dt_zero  = (in_time_step == '0);
  assign sts.div_last = (cnt_r == DIV_CNT_W'(QUO_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= PROD_RESET;
      deg_r  <= DEG_RESET;
      flux_r <= FLUX_RESET;
      upt_r  <= UPT_RESET;
      base_r <= BASE_RESET;
      thr_r  <= THR_RESET;
      ip3_r  <= '0;
      ca_r   <= BASE_RESET;
      last_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROD: prod_r <= cfg_data;
          CFG_DEG:  deg_r  <= cfg_data;
          CFG_FLUX: flux_r <= cfg_data;
          CFG_UPT:  upt_r  <= cfg_data;
          CFG_BASE: begin
            base_r <= cfg_data[CONC_W-1:0];
            ca_r   <= cfg_data[CONC_W-1:0];
          end
          CFG_THR:  thr_r  <= cfg_data[CONC_W-1:0];
          default: ;
        endcase
      end
      if (cmd.ip3_upd) begin
        ip3_r <= ip3_new;
      end
      if (cmd.ca_upd) begin
        ca_r <= ca_new;
        if (spike_hit) begin
          last_r <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt_r   <= in_time_step;
      stim_r <= in_stimulus;
      now_r  <= in_now_us;
    end
    if (cmd.mul_en) begin
      p_r <= mul_p;
    end
    if (cmd.acc_load) begin
      acc_r <= p_r[ACC_W-1:0];
    end else if (cmd.acc_sub) begin
      acc_r <= acc_r - $signed(p_r[ACC_W-1:0]);
    end
    if (cmd.div_init) begin
      rem_r <= ip3_r;
      dvs_r <= ip3_r + Q_ONE;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? IP3_W'(rem2 - {1'b0, dvs_r}) : rem2[IP3_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], div_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.skip_out) begin
      oip3_r <= ip3_r;
      oca_r  <= ca_r;
      ospk_r <= 1'b0;
      oskp_r <= 1'b1;
    end else if (cmd.ca_upd) begin
      oip3_r <= ip3_r;
      oca_r  <= ca_new;
      ospk_r <= spike_hit;
      oskp_r <= 1'b0;
    end
  end

  assign out_ip3_level     = oip3_r;
  assign out_calcium_level = oca_r;
  assign out_spike         = ospk_r;
  assign out_skipped       = oskp_r;

  a_ip3_range: assert property (@(posedge clk) disable iff (!rst_n)
    ip3_r <= IP3_MAX)
    else $error("IP3 state above its upper clamp");

  a_ca_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ca_r >= base_r)
    else $error("calcium state below baseline");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== design/calcium_ip3_cell_update_unit.sv =====
// Top level of the calcium/IP3 cell update unit: ties the sequencer to the
// datapath and the item channels. Depends on ciu_pkg, ciu_in_if, ciu_out_if,
// ciu_ctrl and ciu_dpath.
//
// One item runs one Euler step of a single cell and yields exactly one result.
// A nonzero time step runs six passes through one shared 34x25 multiplier,
// accumulate/subtract and IP3 and calcium update steps, and a restoring divider
// that yields a 16-bit quotient of IP3/(IP3+1). A new item is taken only after
// the result has been taken and the sequencer has returned to idle. A zero time
// step returns the held state in the cycle after acceptance.
// One item is in flight at a time. Configuration writes take effect at once
// and must be made while no item is in flight; writing the baseline also
// reloads calcium.
`default_nettype none

module calcium_ip3_cell_update_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ciu_in_if.sink                              in_ch,
  ciu_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ciu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ciu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ciu_pkg::*;

  ciu_cmd_t cmd;
  ciu_sts_t sts;

  ciu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ciu_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_time_step      (in_ch.time_step),
    .in_stimulus       (in_ch.stimulus),
    .in_now_us         (in_ch.now_us),
    .cmd               (cmd),
    .sts               (sts),
    .out_ip3_level     (out_ch.ip3_level),
    .out_calcium_level (out_ch.calcium_level),
    .out_spike         (out_ch.spike),
    .out_skipped       (out_ch.skipped)
  );

endmodule

`default_nettype wire

// ===== test/calcium_ip3_cell_update_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for calcium_ip3_cell_update_unit. It drives step items with random
// gaps and stalls, predicts each result in fixed point and checks it field by field.
// Depends on ciu_pkg, ciu_in_if, ciu_out_if and the top level of the block.

module calcium_ip3_cell_update_unit_test;
  import ciu_pkg::*;

  localparam int GAP_MAX         = 16;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int SETTLE_CYCLES   = 4;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 100;

  localparam logic [CFG_IDX_W-1:0]     CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0]     CFG_SPARE_HI = 3'd7;
  localparam logic [RATE_W-1:0]        RATE_FULL    = 24'hFFFFFF;
  localparam logic [RATE_W-1:0]        DT_ONE       = 24'd65536;
  localparam logic [RATE_W-1:0]        DT_MIN       = 24'd1;
  localparam logic signed [RATE_W-1:0] STIM_MIN     = 24'sh800000;
  localparam logic signed [RATE_W-1:0] STIM_MAX     = 24'sh7FFFFF;
  localparam logic [CONC_W-1:0]        LEVEL_FULL   = 20'hFFFFF;
  localparam logic [TIME_W-1:0]        TIME_FULL    = 48'hFFFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0]        US_ONE       = 48'd1;

  typedef struct {
    logic [RATE_W-1:0]        time_step;
    logic signed [RATE_W-1:0] stimulus;
    logic [TIME_W-1:0]        now_us;
  } step_item_t;

  typedef struct {
    logic [IP3_W-1:0]  ip3_level;
    logic [CONC_W-1:0] calcium_level;
    logic              spike;
    logic              skipped;
  } cell_state_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ciu_in_if  in_ch();
  ciu_out_if out_ch();

  calcium_ip3_cell_update_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [RATE_W-1:0] prod_rate, deg_rate, flux_rate, upt_rate;
  logic [CONC_W-1:0] base_level, thr_level;
  logic [IP3_W-1:0]  ip3_now;
  logic [CONC_W-1:0] ca_now;
  logic [TIME_W-1:0] last_spike_us;
  logic [TIME_W-1:0] clock_us;

  step_item_t  pending_steps[$];
  cell_state_t expected_cells[$];
  step_item_t  held_step;
  cell_state_t oldest_cell;

  int send_gap     = 0;
  int take_stall   = 0;
  int quiet_cycles = 0;
  int fail_count   = 0;
  bit send_idle_on = 1'b1;
  bit take_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint scaled_increment(longint rate32, logic [RATE_W-1:0] dt);
    longint rate16;
    rate16 = rate32 >>> FRAC_W;
    return (rate16 * longint'(dt)) >>> FRAC_W;
  endfunction

  function automatic cell_state_t advance_cell(step_item_t it);
    cell_state_t r;
    longint rate, ip3, ca, base, factor;
    r.ip3_level     = ip3_now;
    r.calcium_level = ca_now;
    r.spike         = 1'b0;
    r.skipped       = 1'b1;
    if (it.time_step == '0)
      return r;
    rate = longint'(prod_rate) * longint'(it.stimulus)
         - longint'(deg_rate) * longint'(ip3_now);
    ip3 = longint'(ip3_now) + scaled_increment(rate, it.time_step);
    if (ip3 < 0) ip3 = 0;
    if (ip3 > longint'(IP3_MAX)) ip3 = longint'(IP3_MAX);
    base   = longint'(base_level);
    factor = (ip3 * longint'(Q_ONE)) / (ip3 + longint'(Q_ONE));
    rate = longint'(flux_rate) * factor - longint'(upt_rate) * (longint'(ca_now) - base);
    ca = longint'(ca_now) + scaled_increment(rate, it.time_step);
    if (ca > longint'(CA_MAX)) ca = longint'(CA_MAX);
    if (ca < base) ca = base;
    ip3_now = ip3[IP3_W-1:0];
    ca_now  = ca[CONC_W-1:0];
    if (ca >= longint'(thr_level) && (it.now_us - last_spike_us) > REFRACTORY_US) begin
      last_spike_us = it.now_us;
      r.spike = 1'b1;
    end
    r.ip3_level     = ip3_now;
    r.calcium_level = ca_now;
    r.skipped       = 1'b0;
    return r;
  endfunction

  function automatic int draw_wait(bit idle_on);
    return idle_on ? $urandom_range(0, GAP_MAX) : 0;
  endfunction

  function automatic void check_field(string name, logic [CONC_W-1:0] want,
                                      logic [CONC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void queue_step(logic [RATE_W-1:0] dt, logic signed [RATE_W-1:0] stim,
                                     logic [TIME_W-1:0] advance_us);
    step_item_t it;
    clock_us     = clock_us + advance_us;
    it.time_step = dt;
    it.stimulus  = stim;
    it.now_us    = clock_us;
    pending_steps.push_back(it);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return RATE_FULL;
      2: return CFG_DATA_W'($urandom_range(0, 24'h1FFFF));
      3: return CFG_DATA_W'($urandom_range(0, 24'h7FFF));
      4: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(24'hC000, 24'h14000));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CFG_DATA_W'(CA_MAX);
      2: return CFG_DATA_W'($urandom_range(0, CA_MAX));
      3: return CFG_DATA_W'($urandom_range(0, 24'h20000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_PROD: prod_rate = value;
      CFG_DEG:  deg_rate  = value;
      CFG_FLUX: flux_rate = value;
      CFG_UPT:  upt_rate  = value;
      CFG_BASE: begin
        base_level = value[CONC_W-1:0];
        ca_now     = value[CONC_W-1:0];
      end
      CFG_THR:  thr_level = value[CONC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_cell(logic [CFG_DATA_W-1:0] prod, logic [CFG_DATA_W-1:0] deg,
                              logic [CFG_DATA_W-1:0] flux, logic [CFG_DATA_W-1:0] upt,
                              logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] thr);
    write_reg(CFG_PROD, prod);
    write_reg(CFG_DEG, deg);
    write_reg(CFG_FLUX, flux);
    write_reg(CFG_UPT, upt);
    write_reg(CFG_BASE, base);
    write_reg(CFG_THR, thr);
    // spare indexes must leave every register alone
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
  endtask

  task automatic wait_cell_idle();
    @(negedge clk);
    while (pending_steps.size() != 0 || in_ch.valid || expected_cells.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_cells.push_back(advance_cell(held_step));
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0 || pending_steps.size() == 0) begin
          if (in_ch.ready && send_gap > 0)
            send_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          held_step = pending_steps.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.time_step <= held_step.time_step;
          in_ch.stimulus  <= held_step.stimulus;
          in_ch.now_us    <= held_step.now_us;
          if ($urandom_range(0, 31) == 0)
            send_idle_on = !send_idle_on;
          send_gap = draw_wait(send_idle_on);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: result with none expected, ip3=%0d ca=%0d spike=%0b skipped=%0b",
                   $time, out_ch.ip3_level, out_ch.calcium_level, out_ch.spike,
                   out_ch.skipped);
          fail_count++;
        end else begin
          oldest_cell = expected_cells.pop_front();
          check_field("ip3_level", CONC_W'(oldest_cell.ip3_level),
                      CONC_W'(out_ch.ip3_level));
          check_field("calcium_level", oldest_cell.calcium_level, out_ch.calcium_level);
          check_field("spike", CONC_W'(oldest_cell.spike), CONC_W'(out_ch.spike));
          check_field("skipped", CONC_W'(oldest_cell.skipped), CONC_W'(out_ch.skipped));
        end
        if ($urandom_range(0, 31) == 0)
          take_idle_on = !take_idle_on;
        take_stall = draw_wait(take_idle_on);
      end else if (out_ch.valid && take_stall > 0) begin
        take_stall--;
      end
      out_ch.ready <= (take_stall == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.time_step = '0;
    in_ch.stimulus  = '0;
    in_ch.now_us    = '0;
    out_ch.ready    = 1'b0;
    prod_rate       = PROD_RESET;
    deg_rate        = DEG_RESET;
    flux_rate       = FLUX_RESET;
    upt_rate        = UPT_RESET;
    base_level      = BASE_RESET;
    thr_level       = THR_RESET;
    ip3_now         = '0;
    ca_now          = BASE_RESET;
    last_spike_us   = '0;
    clock_us        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_step('0, '0, '0);
    queue_step(DT_ONE, STIM_MAX, US_ONE);
    // land exactly on the refractory edge, then one past it
    queue_step(DT_ONE, STIM_MAX, REFRACTORY_US - US_ONE);
    queue_step(DT_ONE, STIM_MAX, US_ONE);
    queue_step(DT_ONE, STIM_MAX, REFRACTORY_US);
    queue_step(DT_ONE, STIM_MAX, US_ONE);
    queue_step(RATE_FULL, STIM_MAX, US_ONE);
    queue_step('0, STIM_MIN, US_ONE);
    queue_step(RATE_FULL, STIM_MIN, US_ONE);
    queue_step(DT_MIN, STIM_MAX, US_ONE);
    queue_step(DT_MIN, STIM_MIN, US_ONE);
    queue_step(DT_ONE, '0, US_ONE);
    queue_step(DT_ONE, -24'sd65536, US_ONE);
    // wrap the timestamp through the top of its range
    queue_step(DT_ONE, STIM_MAX, TIME_FULL - clock_us);
    queue_step(DT_ONE, STIM_MAX, REFRACTORY_US + US_ONE);
    queue_step(DT_ONE, STIM_MAX, US_ONE);
    queue_step(RATE_FULL, 24'sd1, TIME_FULL);
    wait_cell_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_cell('0, '0, '0, '0, '0, '0);
        1: program_cell(RATE_FULL, RATE_FULL, RATE_FULL, RATE_FULL, CFG_DATA_W'(LEVEL_FULL),
                        CFG_DATA_W'(LEVEL_FULL));
        2: program_cell(PROD_RESET, DEG_RESET, FLUX_RESET, UPT_RESET, CFG_DATA_W'(BASE_RESET),
                        CFG_DATA_W'(THR_RESET));
        3: program_cell(DT_ONE, pick_rate(), RATE_FULL, '0, CFG_DATA_W'(CA_MAX), pick_level());
        default: program_cell(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                              pick_level(), pick_level());
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0: queue_step(RATE_W'($urandom), $signed(RATE_W'($urandom)),
                        TIME_W'({$urandom, $urandom}));
          1: queue_step('0, $signed(RATE_W'($urandom)), TIME_W'($urandom_range(0, 150000)));
          default: queue_step(RATE_W'($urandom_range(1, 2 * DT_ONE)),
                              $urandom_range(0, 2) == 0 ? -$signed(24'($urandom_range(0, 393216)))
                                                        : $signed(24'($urandom_range(0, 393216))),
                              TIME_W'($urandom_range(0, 150000)));
        endcase
      end
      wait_cell_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
